// File: sv/crxaf_pkg.sv
`default_nettype none

package crxaf_pkg;

	// Item codes.
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_RECEIVE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic REG_NORMAL_MODE    = 1'b1;

	localparam int CFG_DATA_W = 6;

	// Result status codes.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_ILLEGAL = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [4:0]  entry_index;
		logic [10:0] filter_id;
		logic [10:0] filter_id_mask;
		logic        filter_rtr;
		logic        has_receiver;
		logic [10:0] frame_id;
		logic        frame_flag;
	} in_item_t;

	typedef struct packed {
		logic       status;
		logic       matched;
		logic [4:0] match_index;
		logic       delivered;
	} out_item_t;

	// One stored filter. Bit 11 of the mask is always set, so only the low
	// eleven mask bits are kept.
	typedef struct packed {
		logic [11:0] ident;
		logic [10:0] mask;
	} entry_t;

	// Outcome of comparing one entry with the received id.
	typedef struct packed {
		logic hit;
		logic has_rx;
	} cmp_res_t;

endpackage

`default_nettype wire

// File: sv/crxaf_stream_if.sv
`default_nettype none

interface crxaf_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/crxaf_ram.sv
`default_nettype none

module crxaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/crxaf_cmp.sv
`default_nettype none

module crxaf_cmp (
	input  wire logic [11:0]       id,
	input  wire crxaf_pkg::entry_t entry,
	input  wire logic              written,
	output      crxaf_pkg::cmp_res_t res
);

	logic [11:0] ident;
	logic [11:0] mask;

	// An entry never written behaves as ident zero with a full mask.
	always_comb begin
		ident = written ? entry.ident : 12'h000;
		mask  = written ? {1'b1, entry.mask} : 12'hFFF;
		res.hit    = (((id ^ ident) & mask) == 12'h000);
		res.has_rx = written;
	end

endmodule

`default_nettype wire

// File: sv/can_rx_acceptance_filter.sv
`default_nettype none

// Channel   Dir  Beat type              Handshake
// in_ch     in   crxaf_pkg::in_item_t   valid/ready, beat on valid && ready
// out_ch    out  crxaf_pkg::out_item_t  valid/ready, beat on valid && ready
// cfg       in   index + data           write on cfg_wr_en, no stall
//
// A write, or a receive outside normal mode or with no entries in use, goes from
// its input beat through the done state to the output register. A normal receive
// scans with one comparator, one entry per cycle from index 0, and stops at the
// first hit or the last entry in use, paced by the one read port of the memory.
// Reset is asynchronous and active low and clears the per-entry written bits.
// A stalled output holds one finished result; the next item is taken, then waits.

module can_rx_acceptance_filter #(
	parameter int FILTER_ENTRIES = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	crxaf_stream_if.sink                        in_ch,
	crxaf_stream_if.source                      out_ch,
	input  wire logic                           cfg_wr_en,
	input  wire logic                           cfg_addr,
	input  wire logic [crxaf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
	localparam logic [7:0] DEPTH8 = 8'(FILTER_ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;

	// Configuration registers.
	logic [5:0] entries_in_use_q;
	logic       normal_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= 6'd32;
			normal_mode_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				crxaf_pkg::REG_ENTRIES_IN_USE: entries_in_use_q <= cfg_wdata[5:0];
				crxaf_pkg::REG_NORMAL_MODE:    normal_mode_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Entries actually in use: a count above the table depth is clipped.
	logic [7:0] ent8;
	logic [7:0] n8;
	assign ent8 = 8'(entries_in_use_q);
	assign n8   = (ent8 > DEPTH8) ? DEPTH8 : ent8;

	logic in_beat;
	logic out_free;
	assign in_beat  = in_ch.valid && in_ch.ready;
	assign out_free = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	// Write path: the entry is stored in the beat cycle itself.
	logic          wr_ok;
	logic          ram_we;
	logic [AW-1:0] wr_addr;
	crxaf_pkg::entry_t wr_entry;

	assign wr_ok   = (8'(in_ch.payload.entry_index) < n8) && in_ch.payload.has_receiver;
	assign ram_we  = in_beat && (in_ch.payload.opcode == crxaf_pkg::OP_WRITE) && wr_ok;
	assign wr_addr = AW'(in_ch.payload.entry_index);
	assign wr_entry.ident = {in_ch.payload.filter_rtr, in_ch.payload.filter_id};
	assign wr_entry.mask  = in_ch.payload.filter_id_mask;

	// One bit per entry marks it written; unwritten entries read as reset.
	logic [FILTER_ENTRIES-1:0] written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	// Scan pointer: index of the entry whose data the memory shows this cycle.
	// While idle the memory keeps reading entry 0, so the first compare can
	// start in the cycle right after the receive beat.
	logic [AW-1:0]     cmp_idx_q;
	logic [AW-1:0]     rd_addr;
	crxaf_pkg::entry_t rd_entry;

	assign rd_addr = (state_q == ST_SCAN) ? AW'(cmp_idx_q + AW'(1)) : '0;

	crxaf_ram #(
		.WIDTH ($bits(crxaf_pkg::entry_t)),
		.DEPTH (FILTER_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	logic [11:0]         id_q;
	crxaf_pkg::cmp_res_t cmp_res;

	crxaf_cmp u_cmp (
		.id      (id_q),
		.entry   (rd_entry),
		.written (written_q[cmp_idx_q]),
		.res     (cmp_res)
	);

	logic [7:0] idx8;
	logic       last_entry;
	assign idx8       = 8'(cmp_idx_q);
	assign last_entry = (idx8 == (n8 - 8'd1));

	// Sequencer and result register.
	crxaf_pkg::out_item_t res_q;
	crxaf_pkg::out_item_t out_q;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmp_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished result loads the output register; otherwise a taken
			// result empties it.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cmp_idx_q <= '0;
					if (in_beat) begin
						if ((in_ch.payload.opcode == crxaf_pkg::OP_RECEIVE) &&
						    normal_mode_q && (n8 != 8'd0)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (cmp_res.hit || last_entry) begin
						state_q <= ST_DONE;
					end else begin
						cmp_idx_q <= AW'(cmp_idx_q + AW'(1));
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			id_q <= {in_ch.payload.frame_flag, in_ch.payload.frame_id};
			res_q.matched     <= 1'b0;
			res_q.match_index <= '0;
			res_q.delivered   <= 1'b0;
			if (in_ch.payload.opcode == crxaf_pkg::OP_WRITE) begin
				res_q.status <= wr_ok ? crxaf_pkg::STATUS_OK : crxaf_pkg::STATUS_ILLEGAL;
			end else begin
				res_q.status <= crxaf_pkg::STATUS_OK;
			end
		end else if ((state_q == ST_SCAN) && cmp_res.hit) begin
			res_q.matched     <= 1'b1;
			res_q.match_index <= idx8[4:0];
			res_q.delivered   <= cmp_res.has_rx;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	// A rejected write never reports a match or a delivery.
	a_write_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.payload.status == crxaf_pkg::STATUS_ILLEGAL)) |->
		(!out_ch.payload.matched && !out_ch.payload.delivered))
		else $error("rejected write carries match fields");

	// Delivery only ever follows a match.
	a_deliver_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.payload.delivered) |-> out_ch.payload.matched)
		else $error("delivered without match");

	// The scan never reaches past the entries in use.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx8 < n8))
		else $error("scan index beyond entries in use");

	// After an input beat the block is busy in the cycle that follows.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ch.ready)
		else $error("input taken twice in a row");

endmodule

`default_nettype wire

// File: verif/can_rx_acceptance_filter_tb.sv
`timescale 1ns / 100ps

module can_rx_acceptance_filter_tb;

	// Self-checking bench for the CAN receive acceptance filter bank.
	//
	// A driver process offers beats from a pending queue and, for every beat the
	// block takes, runs a behavioral copy of the filter table to work out the
	// result it should return. A monitor process takes result beats, stalling at
	// random, and compares each one field by field with the oldest expected
	// result. The stimulus process fills the pending queue one phase at a time
	// and changes the configuration only once the block has gone quiet.

	localparam int FILTER_ENTRIES = 32;
	localparam int RANDOM_PHASES  = 10;

	// A beat waiting to be offered, with the idle cycles the sender spends
	// before offering it.
	typedef struct {
		crxaf_pkg::in_item_t beat;
		int unsigned         gap;
	} pending_beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_addr;
	logic [crxaf_pkg::CFG_DATA_W-1:0] cfg_wdata;

	crxaf_stream_if #(.T(crxaf_pkg::in_item_t))  in_ch ();
	crxaf_stream_if #(.T(crxaf_pkg::out_item_t)) out_ch ();

	can_rx_acceptance_filter #(
		.FILTER_ENTRIES(FILTER_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Behavioral copy of the filter table and of the two registers.
	logic [11:0] flt_ident [FILTER_ENTRIES];
	logic [11:0] flt_mask  [FILTER_ENTRIES];
	logic        flt_has_rx[FILTER_ENTRIES];
	logic [5:0]  flt_count;
	logic        flt_normal;

	pending_beat_t        beat_pending[$];
	crxaf_pkg::out_item_t expected_results[$];
	int unsigned          mismatch_count = 0;

	// Sender and receiver pacing state.
	logic                 tx_burst = 1'b0;
	logic                 tx_armed;
	int unsigned          tx_wait;
	pending_beat_t        tx_next;
	int unsigned          rx_stall;
	int unsigned          rx_beats = 0;
	crxaf_pkg::out_item_t rx_want;

	// Identifiers recently written, so that most received frames are aimed
	// at something the table may actually hold.
	logic [10:0] recent_id[$];
	logic [10:0] recent_mask[$];
	logic        recent_rtr[$];

	// Settings for the random phases. The list covers a count of zero, a
	// single entry, the full table, and counts above the table size, which
	// the block treats as the full table.
	logic [5:0] phase_count [RANDOM_PHASES] = '{32, 8, 63, 1, 0, 32, 33, 16, 5, 32};
	logic       phase_normal[RANDOM_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1};

	// Works out the result of one accepted beat and applies its effect on the
	// table. Only entries below the active count are searched or written.
	function automatic crxaf_pkg::out_item_t filter_outcome(input crxaf_pkg::in_item_t b);
		crxaf_pkg::out_item_t r;
		int                   n;
		logic [11:0]          rx_id;
		logic                 found;
		r = '0;
		r.status = crxaf_pkg::STATUS_OK;
		n = (int'(flt_count) > FILTER_ENTRIES) ? FILTER_ENTRIES : int'(flt_count);
		if (b.opcode == crxaf_pkg::OP_WRITE) begin
			if (int'(b.entry_index) < n && b.has_receiver) begin
				flt_ident[b.entry_index]  = {b.filter_rtr, b.filter_id};
				flt_mask[b.entry_index]   = {1'b1, b.filter_id_mask};
				flt_has_rx[b.entry_index] = 1'b1;
			end else begin
				// Out-of-range index or no receiver: the table is left alone.
				r.status = crxaf_pkg::STATUS_ILLEGAL;
			end
		end else if (flt_normal) begin
			rx_id = {b.frame_flag, b.frame_id};
			found = 1'b0;
			for (int i = 0; i < n; i++) begin
				// The first accepting entry ends the search, whether or not
				// it has a receiver.
				if (!found && ((rx_id ^ flt_ident[i]) & flt_mask[i]) == 12'h000) begin
					found = 1'b1;
					r.matched = 1'b1;
					r.match_index = i[4:0];
					r.delivered = flt_has_rx[i];
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v,
				got_v);
			mismatch_count++;
		end
	endtask

	// Driver. A beat is taken at an edge where valid and ready are both high;
	// its expected result is worked out right there, so the expectation is in
	// the queue long before the block can answer it. When the slot is free,
	// the front pending beat is offered once its gap has run out. With a gap
	// of zero, valid simply stays high from one beat to the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
			tx_armed = 1'b0;
			tx_wait = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(filter_outcome(in_ch.payload));
			if (!in_ch.valid || in_ch.ready) begin
				if (!tx_armed && beat_pending.size() != 0) begin
					tx_wait = beat_pending[0].gap;
					tx_armed = 1'b1;
				end
				if (tx_armed && tx_wait == 0) begin
					tx_next = beat_pending.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.payload <= tx_next.beat;
					tx_armed = 1'b0;
				end else begin
					in_ch.valid <= 1'b0;
					if (tx_armed)
						tx_wait--;
				end
			end
		end
	end

	// Monitor. After each result beat the receiver draws a stall. Every third
	// window of 64 beats it takes results back to back. Twice in the run it
	// holds ready low for a long stretch, so that the output register and the
	// item behind it fill up and the block has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				rx_beats++;
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %p", $time,
						out_ch.payload);
					mismatch_count++;
				end else begin
					rx_want = expected_results.pop_front();
					check_field("status", 32'(rx_want.status),
						32'(out_ch.payload.status));
					check_field("matched", 32'(rx_want.matched),
						32'(out_ch.payload.matched));
					check_field("match_index", 32'(rx_want.match_index),
						32'(out_ch.payload.match_index));
					check_field("delivered", 32'(rx_want.delivered),
						32'(out_ch.payload.delivered));
				end
				if (rx_beats == 60 || rx_beats == 390)
					rx_stall = 200;
				else if (((rx_beats / 64) % 3) == 1)
					rx_stall = 0;
				else
					rx_stall = $urandom_range(0, 19);
			end
			if (rx_stall != 0) begin
				out_ch.ready <= 1'b0;
				rx_stall--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	function automatic crxaf_pkg::in_item_t make_write(input logic [4:0] idx,
			input logic [10:0] id, input logic [10:0] msk, input logic rtr,
			input logic has_rx);
		crxaf_pkg::in_item_t b;
		b.opcode         = crxaf_pkg::OP_WRITE;
		b.entry_index    = idx;
		b.filter_id      = id;
		b.filter_id_mask = msk;
		b.filter_rtr     = rtr;
		b.has_receiver   = has_rx;
		// Fields a write does not use still carry random bits.
		b.frame_id       = 11'($urandom);
		b.frame_flag     = 1'($urandom);
		return b;
	endfunction

	function automatic crxaf_pkg::in_item_t make_receive(input logic [10:0] id,
			input logic flag);
		crxaf_pkg::in_item_t b;
		b.opcode         = crxaf_pkg::OP_RECEIVE;
		b.entry_index    = 5'($urandom);
		b.filter_id      = 11'($urandom);
		b.filter_id_mask = 11'($urandom);
		b.filter_rtr     = 1'($urandom);
		b.has_receiver   = 1'($urandom);
		b.frame_id       = id;
		b.frame_flag     = flag;
		return b;
	endfunction

	task automatic queue_beat(input crxaf_pkg::in_item_t b);
		pending_beat_t p;
		p.beat = b;
		p.gap = tx_burst ? 32'd0 : $urandom_range(0, 19);
		beat_pending.push_back(p);
	endtask

	// Returns on a falling edge once the sender has nothing left and every
	// expected result has come back.
	task automatic wait_quiet();
		@(negedge clk);
		while (beat_pending.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Writes both registers while the block is quiet. The local copy is
	// updated as each write is driven; nothing is in flight, so that is safe.
	task automatic set_config(input logic [5:0] count, input logic normal);
		wait_quiet();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= crxaf_pkg::REG_ENTRIES_IN_USE;
		cfg_wdata <= count;
		flt_count = count;
		@(posedge clk);
		cfg_addr <= crxaf_pkg::REG_NORMAL_MODE;
		cfg_wdata <= {{(crxaf_pkg::CFG_DATA_W - 1){1'b0}}, normal};
		flt_normal = normal;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Random traffic: writes mostly land inside the active range with a
	// receiver, and most frames are built from a recent identifier with
	// random bits flipped only where the mask does not care.
	task automatic queue_random_traffic(input int unsigned count);
		int          lim;
		int unsigned k;
		logic [4:0]  idx;
		logic [10:0] id;
		logic [10:0] msk;
		logic        rtr;
		logic        has_rx;
		lim = (int'(flt_count) > FILTER_ENTRIES) ? FILTER_ENTRIES : int'(flt_count);
		repeat (count) begin
			if ($urandom_range(0, 9) < 4) begin
				id = 11'($urandom);
				case ($urandom_range(0, 9))
					0: msk = 11'h000;
					1, 2, 3: msk = 11'h7FF;
					4, 5: msk = 11'($urandom & $urandom);
					default: msk = 11'($urandom);
				endcase
				rtr = 1'($urandom);
				if (lim != 0 && $urandom_range(0, 6) != 0)
					idx = 5'($urandom_range(0, lim - 1));
				else
					idx = 5'($urandom);
				has_rx = ($urandom_range(0, 9) != 0);
				queue_beat(make_write(idx, id, msk, rtr, has_rx));
				if (recent_id.size() == 16) begin
					void'(recent_id.pop_front());
					void'(recent_mask.pop_front());
					void'(recent_rtr.pop_front());
				end
				recent_id.push_back(id);
				recent_mask.push_back(msk);
				recent_rtr.push_back(rtr);
			end else begin
				if (recent_id.size() != 0 && $urandom_range(0, 9) < 7) begin
					k = $urandom_range(0, recent_id.size() - 1);
					msk = 11'($urandom);
					id = recent_id[k] ^ (msk & ~recent_mask[k]);
					rtr = recent_rtr[k];
					if ($urandom_range(0, 9) == 0)
						rtr = ~rtr;
				end else begin
					id = ($urandom_range(0, 7) == 0) ? 11'h000 : 11'($urandom);
					rtr = 1'($urandom);
				end
				queue_beat(make_receive(id, rtr));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = crxaf_pkg::REG_ENTRIES_IN_USE;
		cfg_wdata = '0;
		for (int i = 0; i < FILTER_ENTRIES; i++) begin
			flt_ident[i] = 12'h000;
			flt_mask[i] = 12'hFFF;
			flt_has_rx[i] = 1'b0;
		end
		flt_count = 6'd32;
		flt_normal = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Out of reset the block is not in normal mode: frames give an empty
		// result, and a write without a receiver is rejected.
		queue_beat(make_receive(11'h000, 1'b0));
		queue_beat(make_receive(11'h7FF, 1'b1));
		queue_beat(make_write(5'd31, 11'h7FF, 11'h7FF, 1'b1, 1'b0));

		set_config(6'd32, 1'b1);
		// A never-written entry accepts id 0 with flag 0 but has no receiver.
		queue_beat(make_receive(11'h000, 1'b0));
		queue_beat(make_receive(11'h7FF, 1'b1));
		queue_beat(make_write(5'd5, 11'h123, 11'h7FF, 1'b0, 1'b1));
		queue_beat(make_receive(11'h123, 1'b0));
		// The flag bit is always compared.
		queue_beat(make_receive(11'h123, 1'b1));
		// An all-zero mask on the top entry takes any frame with the flag set.
		queue_beat(make_write(5'd31, 11'h7FF, 11'h000, 1'b1, 1'b1));
		queue_beat(make_receive(11'h555, 1'b1));
		queue_beat(make_receive(11'h000, 1'b1));
		// Rejected write leaves entry 5 as it was.
		queue_beat(make_write(5'd5, 11'h000, 11'h000, 1'b0, 1'b0));
		queue_beat(make_receive(11'h123, 1'b0));
		queue_beat(make_write(5'd0, 11'h7FF, 11'h7FF, 1'b0, 1'b1));
		queue_beat(make_receive(11'h7FF, 1'b0));
		queue_beat(make_receive(11'h000, 1'b0));
		queue_beat(make_write(5'd1, 11'h400, 11'h000, 1'b0, 1'b1));
		queue_beat(make_receive(11'h2AA, 1'b0));

		// With no entries in use nothing is searched and every write fails.
		set_config(6'd0, 1'b1);
		queue_beat(make_write(5'd0, 11'h001, 11'h7FF, 1'b0, 1'b1));
		queue_beat(make_receive(11'h7FF, 1'b0));

		// A count above the table size acts as the full table.
		set_config(6'd63, 1'b1);
		queue_beat(make_write(5'd31, 11'h2AA, 11'h555, 1'b0, 1'b1));
		queue_beat(make_receive(11'h2AA, 1'b0));
		queue_beat(make_receive(11'h555, 1'b1));

		set_config(6'd1, 1'b1);
		queue_beat(make_write(5'd1, 11'h0F0, 11'h7FF, 1'b1, 1'b1));
		queue_beat(make_write(5'd0, 11'h0F0, 11'h7FF, 1'b1, 1'b1));
		queue_beat(make_receive(11'h0F0, 1'b1));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_config(phase_count[p], phase_normal[p]);
			tx_burst = ((p % 3) == 0);
			queue_random_traffic(65);
		end

		wait_quiet();
		repeat (FILTER_ENTRIES + 8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog, several times the slowest correct run.
	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
